@@ src/rtsp_pkg.sv @@
// Shared types and constants of the RTSP request stream parser.
package rtsp_pkg;

	// Result tags.
	localparam logic [3:0] TAG_METHOD  = 4'd0;
	localparam logic [3:0] TAG_URL     = 4'd1;
	localparam logic [3:0] TAG_VERSION = 4'd2;
	localparam logic [3:0] TAG_HNAME   = 4'd3;
	localparam logic [3:0] TAG_HVALUE  = 4'd4;
	localparam logic [3:0] TAG_LINE_OK = 4'd5;
	localparam logic [3:0] TAG_HDR_OK  = 4'd6;
	localparam logic [3:0] TAG_DONE    = 4'd7;
	localparam logic [3:0] TAG_ERROR   = 4'd8;

	// Error codes.
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_BARE_LF = 3'd1;
	localparam logic [2:0] ERR_SEPS    = 3'd2;
	localparam logic [2:0] ERR_METHOD  = 3'd3;
	localparam logic [2:0] ERR_HEADER  = 3'd4;

	localparam logic [2:0] METH_NONE = 3'd0;

	// Special bytes.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Method keywords, padded to eight characters; the first character is
	// in the top byte.
	localparam int KW_COUNT = 7;
	localparam logic [3:0] POS_MAX = 4'd8;
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		"DESCRIBE", "OPTIONS ", "PLAY    ", "PAUSE   ",
		"SETUP   ", "TEARDOWN", "RECORD  "
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd8, 4'd7, 4'd4, 4'd5, 4'd5, 4'd8, 4'd6
	};

	// Number of result entries buffered ahead of the output.
	localparam int QUEUE_DEPTH = 3;

	// Parser state.
	typedef struct packed {
		logic       phase;
		logic [1:0] fsel;
		logic       cr;
		logic       trunc;
		logic [3:0] pos;
		logic [6:0] km;
		logic [2:0] meth;
		logic       hfault;
	} rtsp_state_t;

	localparam rtsp_state_t STATE_RESET = '{
		phase: 1'b0, fsel: 2'd0, cr: 1'b0, trunc: 1'b0, pos: 4'd0,
		km: 7'h7F, meth: METH_NONE, hfault: 1'b0
	};

	// One result item.
	typedef struct packed {
		logic [3:0] tag;
		logic [7:0] data;
		logic [2:0] meth;
		logic [2:0] err;
	} rtsp_res_t;

	// Outcome of one parsing step: next state and an optional result.
	typedef struct packed {
		rtsp_state_t st;
		logic        emit;
		rtsp_res_t   res;
	} rtsp_step_t;

	// A buffered result with its end-of-byte mark.
	typedef struct packed {
		rtsp_res_t res;
		logic      last;
	} rtsp_entry_t;

endpackage

@@ src/rtsp_request_stream_parser_unit.sv @@
// Top level of the RTSP request stream parser: byte tagging and result queue.
// A result enters the result queue when its byte is accepted and is shown
// on the master side from the queue head. Throughput: one byte per cycle
// while m_tready drains the queue and each byte gives at most one result; a
// byte giving two results (a lone CR then data) holds off input until a pop.
// Reset: arst_n clears the parser state and empties the result queue.
module rtsp_request_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] tag, [11:4] data_byte,
	                               // [14:12] method_code, [17:15] error_code
	output logic        m_tlast
);
	import rtsp_pkg::*;

	rtsp_state_t state_q;
	rtsp_entry_t queue_q [QUEUE_DEPTH];
	logic [1:0]  count_q;

	rtsp_step_t  step_a;
	rtsp_step_t  step_b;
	rtsp_state_t state_d;
	logic        a_done;
	logic        accept;
	logic        pop;
	logic [1:0]  push_n;
	rtsp_entry_t first_e;
	rtsp_entry_t second_e;
	rtsp_entry_t queue_d [QUEUE_DEPTH];
	logic [1:0]  base;
	logic [1:0]  count_d;

	// An error result that also returns the parser to reset.
	function automatic rtsp_step_t error_step(input logic [2:0] code);
		rtsp_step_t o;
		o.st = STATE_RESET;
		o.emit = 1'b1;
		o.res = '{tag: TAG_ERROR, data: 8'd0, meth: METH_NONE, err: code};
		return o;
	endfunction

	function automatic rtsp_state_t clear_line(input rtsp_state_t s);
		rtsp_state_t o;
		o = s;
		o.fsel = 2'd0;
		o.cr = 1'b0;
		o.trunc = 1'b0;
		o.pos = 4'd0;
		o.km = 7'h7F;
		o.hfault = 1'b0;
		return o;
	endfunction

	// One data byte: field changes, tagging and keyword matching.
	function automatic rtsp_step_t data_step(input rtsp_state_t s, input logic [7:0] b);
		rtsp_step_t o;
		logic [7:0] u;
		logic [63:0] word;
		o.st = s;
		o.emit = 1'b0;
		o.res = '{tag: TAG_METHOD, data: b, meth: s.meth, err: ERR_NONE};
		u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
		if (b == CH_NUL) begin
			o.st.trunc = 1'b1;
		end else if (!s.phase) begin
			if ((b == CH_SPACE || b == CH_TAB) && s.fsel < 2'd2) begin
				o.st.fsel = s.fsel + 2'd1;
			end else begin
				o.emit = 1'b1;
				o.res.tag = {2'b00, s.fsel};
				if (s.fsel == 2'd0 && s.pos < POS_MAX) begin
					for (int k = 0; k < KW_COUNT; k++) begin
						word = KW_TEXT[k];
						if (s.pos < KW_LEN[k] && u != word[(7 - s.pos[2:0]) * 8 +: 8])
							o.st.km[k] = 1'b0;
					end
					o.st.pos = s.pos + 4'd1;
				end
			end
		end else begin
			if (s.fsel == 2'd0 && b == CH_COLON) begin
				if (s.pos == 4'd0)
					o.st.hfault = 1'b1;
				o.st.fsel = 2'd1;
			end else begin
				o.emit = 1'b1;
				o.res.tag = TAG_HNAME + {3'b000, s.fsel[0]};
				if (s.fsel == 2'd0 && s.pos < POS_MAX)
					o.st.pos = s.pos + 4'd1;
			end
		end
		return o;
	endfunction

	// CR LF: judge the line that just ended.
	function automatic rtsp_step_t line_end(input rtsp_state_t s);
		rtsp_step_t o;
		logic       found;
		logic [2:0] hit;
		o.st = s;
		o.emit = 1'b1;
		o.res = '{tag: TAG_HDR_OK, data: 8'd0, meth: s.meth, err: ERR_NONE};
		found = 1'b0;
		hit = 3'd0;
		// Lowest matching keyword wins.
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (s.km[k] && s.pos >= KW_LEN[k]) begin
				found = 1'b1;
				hit = 3'(k + 1);
			end
		end
		if (!s.phase) begin
			if (s.fsel < 2'd2) begin
				o = error_step(ERR_SEPS);
			end else if (!found) begin
				o = error_step(ERR_METHOD);
			end else begin
				o.st = clear_line(s);
				o.st.phase = 1'b1;
				o.st.meth = hit;
				o.res.tag = TAG_LINE_OK;
				o.res.meth = hit;
			end
		end else if (s.hfault) begin
			o = error_step(ERR_HEADER);
		end else if (s.fsel == 2'd0) begin
			if (s.pos == 4'd0) begin
				o.st = STATE_RESET;
				o.res.tag = TAG_DONE;
			end else begin
				o = error_step(ERR_HEADER);
			end
		end else begin
			o.st = clear_line(s);
		end
		return o;
	endfunction

	// Parse one byte: a pending CR is resolved first, then the byte itself.
	always_comb begin
		step_a.st = state_q;
		step_a.emit = 1'b0;
		step_a.res = '0;
		a_done = 1'b0;
		if (state_q.cr) begin
			step_a.st.cr = 1'b0;
			if (s_tdata == CH_LF) begin
				step_a = line_end(step_a.st);
				a_done = 1'b1;
			end else if (!state_q.trunc) begin
				step_a = data_step(step_a.st, CH_CR);
			end
		end
		step_b.st = step_a.st;
		step_b.emit = 1'b0;
		step_b.res = '0;
		if (!a_done) begin
			if (s_tdata == CH_CR)
				step_b.st.cr = 1'b1;
			else if (s_tdata == CH_LF)
				step_b = error_step(ERR_BARE_LF);
			else if (!step_a.st.trunc)
				step_b = data_step(step_a.st, s_tdata);
		end
		state_d = step_b.st;
	end

	// Order the results of this byte and mark the final one.
	always_comb begin
		push_n = {1'b0, step_a.emit} + {1'b0, step_b.emit};
		first_e.res = step_a.emit ? step_a.res : step_b.res;
		first_e.last = !(step_a.emit && step_b.emit);
		second_e.res = step_b.res;
		second_e.last = 1'b1;
	end

	// Handshake: accept a byte whenever two queue entries are free.
	assign s_tready = (count_q <= 2'd1);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = (count_q != 2'd0);
	assign pop = m_tvalid && m_tready;
	assign m_tdata = {6'd0, queue_q[0].res.err, queue_q[0].res.meth,
		queue_q[0].res.data, queue_q[0].res.tag};
	assign m_tlast = queue_q[0].last;

	// Result queue: shift out at the head, append behind the survivors.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++)
			queue_d[i] = pop ? queue_q[i + 1] : queue_q[i];
		queue_d[QUEUE_DEPTH - 1] = queue_q[QUEUE_DEPTH - 1];
		base = count_q - {1'b0, pop};
		count_d = base;
		if (accept) begin
			if (push_n != 2'd0)
				queue_d[base] = first_e;
			if (push_n == 2'd2)
				queue_d[base + 2'd1] = second_e;
			count_d = base + push_n;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
			if (accept)
				state_q <= state_d;
		end
	end

	// Queue payload.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++)
			queue_q[i] <= queue_d[i];
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd3)
		else $error("result queue count out of range");

	a_lf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata == CH_LF) |=> (count_q != 2'd0))
		else $error("LF byte produced no result");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:0] == TAG_ERROR) |->
		(m_tdata[17:15] != ERR_NONE && m_tdata[14:12] == METH_NONE))
		else $error("error result with bad fields");

	a_noerror_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:0] != TAG_ERROR) |-> (m_tdata[17:15] == ERR_NONE))
		else $error("error code on a non-error result");
`endif

endmodule
